// ----- hw/rtl/uvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and fixed-point helpers of the UV sphere generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	// width of a step count register
	localparam int STEP_W = 11;

	// largest usable step count; row and column fields are 10 bits wide
	localparam int MAX_STEPS = 1024;

	// configuration register indexes
	localparam logic [0:0] CFG_VSTEPS = 1'b0;
	localparam logic [0:0] CFG_HSTEPS = 1'b1;

	// restoring divider: quotient bits resolved per stage, stage count
	localparam int DIV_SPS = 4;
	localparam int DIV_LAT = 6;

	// sine/cosine pipeline depth, output rounding depth, index depth
	localparam int SC_LAT   = 11;
	localparam int POST_LAT = 2;
	localparam int IDX_LAT  = 2;

	// Q2.30 one and pi/2
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

	// reciprocals for exact floor division of 31-bit values by constants:
	// m = ceil(2^k / c), k = 31 + ceil(log2 c)
	localparam int K_6  = 34;
	localparam int K_12 = 35;
	localparam int K_20 = 36;
	localparam int K_30 = 36;
	localparam int K_42 = 37;
	localparam int K_56 = 37;
	localparam int K_72 = 38;
	localparam int K_90 = 38;
	localparam logic [31:0] RCP_6  = 32'(((64'd1 << K_6)  + 64'd5)  / 64'd6);
	localparam logic [31:0] RCP_12 = 32'(((64'd1 << K_12) + 64'd11) / 64'd12);
	localparam logic [31:0] RCP_20 = 32'(((64'd1 << K_20) + 64'd19) / 64'd20);
	localparam logic [31:0] RCP_30 = 32'(((64'd1 << K_30) + 64'd29) / 64'd30);
	localparam logic [31:0] RCP_42 = 32'(((64'd1 << K_42) + 64'd41) / 64'd42);
	localparam logic [31:0] RCP_56 = 32'(((64'd1 << K_56) + 64'd55) / 64'd56);
	localparam logic [31:0] RCP_72 = 32'(((64'd1 << K_72) + 64'd71) / 64'd72);
	localparam logic [31:0] RCP_90 = 32'(((64'd1 << K_90) + 64'd89) / 64'd90);

	// triangle indices of one quad
	typedef struct packed {
		logic        valid;
		logic [19:0] b2;
		logic [19:0] b1;
		logic [19:0] b0;
		logic [19:0] a2;
		logic [19:0] a1;
		logic [19:0] a0;
	} tri_t;

	// one result word
	typedef struct packed {
		tri_t        tris;
		logic [16:0] tex_v;
		logic [16:0] tex_u;
		logic [15:0] pos_z;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
	} res_t;

	// Q2.30 product, truncated
	function automatic logic [30:0] mulq(input logic [30:0] x, input logic [30:0] y);
		logic [61:0] p;
		p = x * y;
		return p[60:30];
	endfunction

	// floor(x / c) through the reciprocal m = ceil(2^k / c)
	function automatic logic [30:0] divc(input logic [30:0] x, input logic [31:0] m,
			input int k);
		logic [62:0] p;
		p = x * m;
		return 31'(p >> k);
	endfunction

endpackage

// ----- hw/rtl/uvs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: q = floor(x * 2^(STEPS-1) / d) for x <= d.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; #(
	parameter int STEPS = 22
) (
	input  logic              clk,
	input  logic              en,
	input  logic [STEP_W-1:0] x,
	input  logic [STEP_W-1:0] d,
	output logic [STEPS-1:0]  q
);

	logic [STEP_W-1:0] rem_s [1:DIV_LAT-1];
	logic [STEPS-1:0]  quo_s [1:DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stg
		logic [STEP_W-1:0] rem_in;
		logic [STEP_W-1:0] rem_nx;
		logic [STEPS-1:0]  quo_in;
		logic [STEPS-1:0]  quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = x;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign quo_in = quo_s[k];
		end

		// DIV_SPS compare-subtract steps; the first one of stage 0 yields the integer bit
		always_comb begin : p_step
			logic [STEP_W:0] r2;
			logic            qbit;
			rem_nx = rem_in;
			quo_nx = quo_in;
			r2     = '0;
			qbit   = 1'b0;
			for (int i = 0; i < DIV_SPS; i++) begin
				if (k * DIV_SPS + i < STEPS) begin
					r2 = (k * DIV_SPS + i == 0) ? {1'b0, rem_nx} : {rem_nx, 1'b0};
					qbit = (r2 >= {1'b0, d});
					if (qbit) begin
						r2 = r2 - {1'b0, d};
					end
					rem_nx = r2[STEP_W-1:0];
					quo_nx = {quo_nx[STEPS-2:0], qbit};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= quo_nx;
			end
		end

		if (k < DIV_LAT - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= rem_nx;
				end
			end
		end
	end

	assign q = quo_s[DIV_LAT];

endmodule

// ----- hw/rtl/uvs_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sincos
// Sine and cosine (Q2.30 signed) of a 20-bit full-turn phase, Horner series.
// ----------------------------------------------------------------------------
module uvs_sincos import uvs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [19:0]        phase,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);

	logic [1:0]  quad_s [1:10];
	logic        swap_s [1:10];
	logic [29:0] a_s    [1:9];
	logic [29:0] a2_s   [2:9];
	logic [30:0] ts_s3, ts_s5, ts_s7, ts_s9;
	logic [30:0] tc_s3, tc_s5, tc_s7, tc_s9;
	logic [30:0] ps_s4, ps_s6, ps_s8;
	logic [30:0] pc_s4, pc_s6, pc_s8, pc_s10;
	logic [30:0] sin_s10;

	logic [17:0] rem_ph;
	logic        swap_c;
	logic [17:0] red_ph;
	logic [48:0] ang_p;

	// octant reduction and angle in radians
	always_comb begin
		rem_ph = phase[17:0];
		swap_c = (rem_ph > 18'h2_0000);
		red_ph = swap_c ? 18'(19'h4_0000 - {1'b0, rem_ph}) : rem_ph;
		ang_p  = red_ph * PI_HALF_Q30;
	end

	// stage 1 and 2: angle, angle squared
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[1] <= phase[19:18];
			swap_s[1] <= swap_c;
			a_s[1]    <= ang_p[47:18];
			a2_s[2]   <= 30'(mulq({1'b0, a_s[1]}, {1'b0, a_s[1]}));
			for (int k = 2; k <= 10; k++) begin
				quad_s[k] <= quad_s[k-1];
				swap_s[k] <= swap_s[k-1];
			end
			for (int k = 2; k <= 9; k++) begin
				a_s[k] <= a_s[k-1];
			end
			for (int k = 3; k <= 9; k++) begin
				a2_s[k] <= a2_s[k-1];
			end
		end
	end

	// Horner chain: products and constant divisions alternate by stage
	always_ff @(posedge clk) begin
		if (en) begin
			ts_s3   <= ONE_Q30 - divc({1'b0, a2_s[2]}, RCP_72, K_72);
			tc_s3   <= ONE_Q30 - divc({1'b0, a2_s[2]}, RCP_90, K_90);
			ps_s4   <= mulq({1'b0, a2_s[3]}, ts_s3);
			pc_s4   <= mulq({1'b0, a2_s[3]}, tc_s3);
			ts_s5   <= ONE_Q30 - divc(ps_s4, RCP_42, K_42);
			tc_s5   <= ONE_Q30 - divc(pc_s4, RCP_56, K_56);
			ps_s6   <= mulq({1'b0, a2_s[5]}, ts_s5);
			pc_s6   <= mulq({1'b0, a2_s[5]}, tc_s5);
			ts_s7   <= ONE_Q30 - divc(ps_s6, RCP_20, K_20);
			tc_s7   <= ONE_Q30 - divc(pc_s6, RCP_30, K_30);
			ps_s8   <= mulq({1'b0, a2_s[7]}, ts_s7);
			pc_s8   <= mulq({1'b0, a2_s[7]}, tc_s7);
			ts_s9   <= ONE_Q30 - divc(ps_s8, RCP_6, K_6);
			tc_s9   <= ONE_Q30 - divc(pc_s8, RCP_12, K_12);
			sin_s10 <= mulq({1'b0, a_s[9]}, ts_s9);
			pc_s10  <= mulq({1'b0, a2_s[9]}, tc_s9);
		end
	end

	logic [30:0]        cos_v;
	logic signed [31:0] sq;
	logic signed [31:0] cq;
	logic signed [31:0] s_nx;
	logic signed [31:0] c_nx;

	// final cosine term, octant swap, quadrant signs
	always_comb begin
		cos_v = ONE_Q30 - (pc_s10 >> 1);
		sq    = swap_s[10] ? $signed({1'b0, cos_v}) : $signed({1'b0, sin_s10});
		cq    = swap_s[10] ? $signed({1'b0, sin_s10}) : $signed({1'b0, cos_v});
		case (quad_s[10])
			2'd0: begin s_nx = sq;  c_nx = cq;  end
			2'd1: begin s_nx = cq;  c_nx = -sq; end
			2'd2: begin s_nx = -sq; c_nx = -cq; end
			default: begin s_nx = -cq; c_nx = sq; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= s_nx;
			cos_o <= c_nx;
		end
	end

endmodule

// ----- hw/rtl/uvs_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_post
// Position products and rounding to clamped Q2.14.
// ----------------------------------------------------------------------------
module uvs_post import uvs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] st,
	input  logic signed [31:0] ct,
	input  logic signed [31:0] sp,
	input  logic signed [31:0] cp,
	output logic [15:0]        pos_x,
	output logic [15:0]        pos_y,
	output logic [15:0]        pos_z
);

	logic signed [63:0] px_s1;
	logic signed [63:0] pz_s1;
	logic signed [31:0] cp_s1;

	// round right by sh, half away from zero, clamp to one
	function automatic logic [15:0] rnd_q14(input logic signed [63:0] v, input int sh);
		logic        neg;
		logic [63:0] m;
		neg = v[63];
		m   = neg ? 64'(-v) : 64'(v);
		m   = (m + (64'd1 << (sh - 1))) >> sh;
		if (m > 64'd16384) begin
			m = 64'd16384;
		end
		return neg ? 16'(-m) : 16'(m);
	endfunction

	// products of the spherical terms
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= ct * sp;
			pz_s1 <= st * sp;
			cp_s1 <= cp;
		end
	end

	// rounding
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= rnd_q14(px_s1, 46);
			pos_y <= rnd_q14(64'(cp_s1), 16);
			pos_z <= rnd_q14(pz_s1, 46);
		end
	end

endmodule

// ----- hw/rtl/uvs_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_index
// Triangle indices of the quad at one grid point, column wrapped.
// ----------------------------------------------------------------------------
module uvs_index import uvs_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [9:0]        row,
	input  logic [9:0]        col,
	input  logic [STEP_W-1:0] h,
	input  logic [STEP_W-1:0] dv,
	output tri_t              tri_o
);

	logic [20:0]       rowh_s1;
	logic [9:0]        col_s1;
	logic [STEP_W-1:0] nc_s1;
	logic [STEP_W-1:0] h_s1;
	logic              tv_s1;

	logic [STEP_W-1:0] col_inc;

	assign col_inc = STEP_W'(col) + STEP_W'(1);

	// row base and wrapped next column
	always_ff @(posedge clk) begin
		if (en) begin
			rowh_s1 <= row * h;
			col_s1  <= col;
			nc_s1   <= (col_inc == h) ? '0 : col_inc;
			h_s1    <= h;
			tv_s1   <= (STEP_W'(row) < dv);
		end
	end

	logic [21:0] cur_c;
	logic [21:0] nr_c;
	logic [21:0] a1_c;
	logic [21:0] a2_c;
	logic [21:0] b1_c;

	always_comb begin
		cur_c = 22'(rowh_s1) + 22'(col_s1);
		nr_c  = 22'(rowh_s1) + 22'(h_s1);
		a1_c  = nr_c + 22'(nc_s1);
		a2_c  = nr_c + 22'(col_s1);
		b1_c  = 22'(rowh_s1) + 22'(nc_s1);
	end

	// last row gives all zeros
	always_ff @(posedge clk) begin
		if (en) begin
			if (tv_s1) begin
				tri_o.valid <= 1'b1;
				tri_o.a0    <= cur_c[19:0];
				tri_o.a1    <= a1_c[19:0];
				tri_o.a2    <= a2_c[19:0];
				tri_o.b0    <= cur_c[19:0];
				tri_o.b1    <= b1_c[19:0];
				tri_o.b2    <= a1_c[19:0];
			end else begin
				tri_o <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/uv_sphere_vertex_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// Vertex position, texture coordinates and quad indices of a UV sphere point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per grid point (row, column). Output stream m_*:
//   one result word per input word, in order. Configuration writes set the
//   vertical and horizontal step counts; write them only while the block is
//   idle. Out-of-range steps are clamped to 2..MAX_STEPS.
//   Pipeline: the clamp stage takes the word at the accepting edge, followed
//   by 6 divider stages at 4 quotient bits each, 11 sine/cosine stages,
//   2 rounding stages and the output register that drives m_tvalid.
//   Throughput: one word per cycle, sustained while m_tready stays high.
//   Reset: the step registers return to 50 and the pipeline empties.
//   Stall: while m_tready is low the result stays on m_tdata; the next word
//   from the pipeline lands in a skid register, after which s_tready drops and
//   the whole pipeline holds until the skid register drains.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core import uvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // row[9:0], column[19:10], zero pad
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [207:0]      m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
	                                     // tri_index_a0..a2, b0..b2, zero pad
	output logic              m_tuser,   // tri_valid
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [STEP_W-1:0] cfg_wdata
);

	localparam int S_DIV = 1 + DIV_LAT;
	localparam int S_SC  = S_DIV + SC_LAT;
	localparam int S_OUT = S_SC + POST_LAT;
	localparam int S_IDX = 1 + IDX_LAT;

	// step registers
	logic [STEP_W-1:0] vsteps_q;
	logic [STEP_W-1:0] hsteps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsteps_q <= STEP_W'(50);
			hsteps_q <= STEP_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VSTEPS: vsteps_q <= cfg_wdata;
				CFG_HSTEPS: hsteps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamped steps and divisors
	logic [STEP_W-1:0] vc, hc, dv, dh;

	always_comb begin
		if (vsteps_q < STEP_W'(2)) begin
			vc = STEP_W'(2);
		end else if (13'(vsteps_q) > 13'(MAX_STEPS)) begin
			vc = STEP_W'(MAX_STEPS);
		end else begin
			vc = vsteps_q;
		end
		if (hsteps_q < STEP_W'(2)) begin
			hc = STEP_W'(2);
		end else if (13'(hsteps_q) > 13'(MAX_STEPS)) begin
			hc = STEP_W'(MAX_STEPS);
		end else begin
			hc = hsteps_q;
		end
		dv = vc - STEP_W'(1);
		dh = hc - STEP_W'(1);
	end

	// pipeline control: everything advances unless the skid register is full
	logic             adv;
	logic [S_OUT:1]   vld_s;
	logic             out_v_q;
	logic             skid_v_q;
	res_t             out_q;
	res_t             skid_q;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[S_OUT-1:1], s_tvalid};
		end
	end

	// stage 1: clamp row and column
	logic [9:0] row_in, col_in;
	logic [9:0] row_s1, col_s1;

	assign row_in = s_tdata[9:0];
	assign col_in = s_tdata[19:10];

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= (STEP_W'(row_in) > dv) ? dv[9:0] : row_in;
			col_s1 <= (STEP_W'(col_in) > dh) ? dh[9:0] : col_in;
		end
	end

	// dividers: row * 2^20 / dv and column * 2^21 / dh
	logic [20:0] qr;
	logic [21:0] qc;

	uvs_div #(.STEPS(21)) u_div_row (
		.clk (clk),
		.en  (adv),
		.x   (STEP_W'(row_s1)),
		.d   (dv),
		.q   (qr)
	);

	uvs_div #(.STEPS(22)) u_div_col (
		.clk (clk),
		.en  (adv),
		.x   (STEP_W'(col_s1)),
		.d   (dh),
		.q   (qc)
	);

	// rounded phases and texture coordinates from the floor quotients
	logic [19:0] pphase, tphase;
	logic [16:0] tex_u_c, tex_v_c;
	logic [21:0] qr_inc;
	logic [22:0] qc_inc;
	logic [17:0] qr_tex;
	logic [17:0] qc_tex;

	always_comb begin
		qr_inc  = 22'(qr) + 22'(1);
		qc_inc  = 23'(qc) + 23'(1);
		pphase  = qr_inc[20:1];
		tphase  = qc_inc[20:1];
		qr_tex  = 18'(qr >> 3) + 18'(1);
		qc_tex  = 18'(qc >> 4) + 18'(1);
		tex_u_c = qr_tex[17:1];
		tex_v_c = qc_tex[17:1];
	end

	// sine and cosine of both angles
	logic signed [31:0] st, ct, sp, cp;

	uvs_sincos u_sc_theta (
		.clk   (clk),
		.en    (adv),
		.phase (tphase),
		.sin_o (st),
		.cos_o (ct)
	);

	uvs_sincos u_sc_phi (
		.clk   (clk),
		.en    (adv),
		.phase (pphase),
		.sin_o (sp),
		.cos_o (cp)
	);

	logic [15:0] pos_x, pos_y, pos_z;

	uvs_post u_post (
		.clk   (clk),
		.en    (adv),
		.st    (st),
		.ct    (ct),
		.sp    (sp),
		.cp    (cp),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z)
	);

	// triangle indices
	tri_t tri_c;

	uvs_index u_index (
		.clk   (clk),
		.en    (adv),
		.row   (row_s1),
		.col   (col_s1),
		.h     (hc),
		.dv    (dv),
		.tri_o (tri_c)
	);

	// delay lines aligning texture and indices with the position
	logic [16:0] tex_u_s [S_DIV+1:S_OUT];
	logic [16:0] tex_v_s [S_DIV+1:S_OUT];
	tri_t        tri_s   [S_IDX+1:S_OUT];

	always_ff @(posedge clk) begin
		if (adv) begin
			tex_u_s[S_DIV+1] <= tex_u_c;
			tex_v_s[S_DIV+1] <= tex_v_c;
			for (int k = S_DIV + 2; k <= S_OUT; k++) begin
				tex_u_s[k] <= tex_u_s[k-1];
				tex_v_s[k] <= tex_v_s[k-1];
			end
			tri_s[S_IDX+1] <= tri_c;
			for (int k = S_IDX + 2; k <= S_OUT; k++) begin
				tri_s[k] <= tri_s[k-1];
			end
		end
	end

	// final word of the pipeline
	res_t res_c;

	always_comb begin
		res_c.pos_x = pos_x;
		res_c.pos_y = pos_y;
		res_c.pos_z = pos_z;
		res_c.tex_u = tex_u_s[S_OUT];
		res_c.tex_v = tex_v_s[S_OUT];
		res_c.tris  = tri_s[S_OUT];
	end

	// output register with skid
	logic take;

	assign take = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (adv && vld_s[S_OUT]) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[S_OUT]) begin
			if (!out_v_q || take) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.tris.valid;
	assign m_tdata  = {6'b0, out_q.tris.b2, out_q.tris.b1, out_q.tris.b0,
		out_q.tris.a2, out_q.tris.a1, out_q.tris.a0, out_q.tex_v, out_q.tex_u,
		out_q.pos_z, out_q.pos_y, out_q.pos_x};

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_last_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[201:82] == '0))
		else $error("indices not cleared on last row");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(out_q.pos_x) >= -16384 && $signed(out_q.pos_x) <= 16384
			&& $signed(out_q.pos_y) >= -16384 && $signed(out_q.pos_y) <= 16384
			&& $signed(out_q.pos_z) >= -16384 && $signed(out_q.pos_z) <= 16384))
		else $error("position out of Q2.14 unit range");

endmodule
